[rtl/core/utfx_pkg.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// utfx_pkg
// Shared types, constants and text tables of the UTF-8 validating XML escaper.
// -----------------------------------------------------------------------------
package utfx_pkg;

   localparam int unsigned RAW_MAX = 4;   // longest UTF-8 character in bytes

   localparam logic [20:0] CP_MAX      = 21'h10FFFF;
   localparam logic [20:0] SURR_LO     = 21'h00D800;
   localparam logic [20:0] SURR_HI     = 21'h00DFFF;
   localparam logic [20:0] NONCHAR_LO  = 21'h00FFFE;
   localparam logic [20:0] NONCHAR_HI  = 21'h00FFFF;
   localparam logic [20:0] MIN_CP_2    = 21'h000080;
   localparam logic [20:0] MIN_CP_3    = 21'h000800;
   localparam logic [20:0] MIN_CP_4    = 21'h010000;

   localparam logic [7:0] LEAD2_LO = 8'hC2;
   localparam logic [7:0] LEAD2_HI = 8'hDF;
   localparam logic [7:0] LEAD3_LO = 8'hE0;
   localparam logic [7:0] LEAD3_HI = 8'hEF;
   localparam logic [7:0] LEAD4_LO = 8'hF0;
   localparam logic [7:0] LEAD4_HI = 8'hF4;

   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_LT    = 8'h3C;
   localparam logic [7:0] CH_GT    = 8'h3E;
   localparam logic [7:0] CH_QUOT  = 8'h22;
   localparam logic [7:0] CH_APOS  = 8'h27;

   // Texts left-justified in 64 bits, first character in the top byte.
   localparam logic [63:0] TXT_REPL = "&#xFFFD;";
   localparam logic [63:0] TXT_AMP  = {"&amp;", 24'h0};
   localparam logic [63:0] TXT_LT   = {"&lt;", 32'h0};
   localparam logic [63:0] TXT_GT   = {"&gt;", 32'h0};
   localparam logic [63:0] TXT_QUOT = {"&quot;", 16'h0};
   localparam logic [63:0] TXT_APOS = {"&apos;", 16'h0};

   typedef enum logic [1:0] {
      BODY_NONE,
      BODY_RAW,
      BODY_TEXT
   } body_type;

   typedef enum logic [2:0] {
      TEXT_REPL,
      TEXT_AMP,
      TEXT_LT,
      TEXT_GT,
      TEXT_QUOT,
      TEXT_APOS
   } text_type;

   // One queued word: some replacement texts, then an optional body.
   typedef struct packed {
      logic [2:0]                 rep;       // number of &#xFFFD; texts first
      body_type                   body;
      text_type                   text;
      logic [2:0]                 raw_len;   // 1..4
      logic [RAW_MAX-1:0][7:0]    raw;
      logic                       eos;
   } cmd_type;

   function automatic logic [7:0] text_byte(text_type t, logic [2:0] pos);
      logic [63:0] txt;
      logic [63:0] sh;
      unique case (t)
         TEXT_REPL: txt = TXT_REPL;
         TEXT_AMP:  txt = TXT_AMP;
         TEXT_LT:   txt = TXT_LT;
         TEXT_GT:   txt = TXT_GT;
         TEXT_QUOT: txt = TXT_QUOT;
         TEXT_APOS: txt = TXT_APOS;
         default:   txt = TXT_REPL;
      endcase
      sh = txt << {pos, 3'b000};
      return sh[63:56];
   endfunction

   function automatic logic [2:0] text_last(text_type t);
      logic [2:0] last;
      unique case (t)
         TEXT_REPL: last = 3'd7;
         TEXT_AMP:  last = 3'd4;
         TEXT_LT:   last = 3'd3;
         TEXT_GT:   last = 3'd3;
         TEXT_QUOT: last = 3'd5;
         TEXT_APOS: last = 3'd5;
         default:   last = 3'd7;
      endcase
      return last;
   endfunction

endpackage

[rtl/core/utf8_validating_xml_escaper.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// utf8_validating_xml_escaper
// Streams raw string bytes in and escaped, UTF-8 checked XML text bytes out.
// -----------------------------------------------------------------------------
// Usage:
//   req_* takes one string byte per word with its end-of-string and quote
//   flags; rsp_* returns one text byte per word. rsp_run_last marks the last
//   byte caused by an input byte, rsp_string_end the last byte of the string.
//   Bytes of an open multibyte character are held in the classifier and give
//   no output until the character completes or breaks.
// Timing:
//   The classifier takes one byte per cycle while the queue has room and
//   turns it into at most one command word; the expander sends that word's
//   bytes one per cycle while rsp_ready is high (1 to 32). Each word passes
//   the queue, then the output register. Throughput is one input byte per cycle
//   while each gives one output byte and rsp_ready is high; longer expansions
//   hold the input once the 2-word queue fills, so input follows the output.
// Reset and stalls:
//   Reset drops any open sequence, the queue and the output register.
//   While rsp_ready is low the output word holds; the queue fills and then
//   req_ready falls.
// -----------------------------------------------------------------------------
module utf8_validating_xml_escaper (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  logic [7:0] req_in_byte,
   input  logic       req_end_of_string,
   input  logic       req_quote_escape,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   output logic [7:0] rsp_out_byte,
   output logic       rsp_run_last,
   output logic       rsp_string_end
);
   import utfx_pkg::*;

   logic    f_valid;
   logic    f_ready;
   cmd_type f_cmd;
   logic    q_valid;
   logic    q_pop;
   cmd_type q_cmd;

   utfx_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .req_quote_escape  (req_quote_escape),
      .cmd_valid         (f_valid),
      .cmd               (f_cmd),
      .cmd_ready         (f_ready)
   );

   utfx_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (f_valid),
      .wr_ready (f_ready),
      .wr_cmd   (f_cmd),
      .rd_valid (q_valid),
      .rd_pop   (q_pop),
      .rd_cmd   (q_cmd)
   );

   utfx_back u_back (
      .clock          (clock),
      .reset          (reset),
      .cmd_valid      (q_valid),
      .cmd            (q_cmd),
      .cmd_pop        (q_pop),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_out_byte   (rsp_out_byte),
      .rsp_run_last   (rsp_run_last),
      .rsp_string_end (rsp_string_end)
   );

endmodule

[rtl/core/utfx_front.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// utfx_front
// Input side: UTF-8 sequence tracking and classification of each byte into
// at most one output command word.
// -----------------------------------------------------------------------------
module utfx_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_in_byte,
   input  logic              req_end_of_string,
   input  logic              req_quote_escape,
   output logic              cmd_valid,
   output utfx_pkg::cmd_type cmd,
   input  logic              cmd_ready
);
   import utfx_pkg::*;

   logic [2:0][7:0] pend_ff, pend_in;
   logic [1:0]      pcnt_ff, pcnt_in;
   logic [2:0]      elen_ff, elen_in;
   logic [20:0]     cp_ff, cp_in;

   logic        accept;
   logic [7:0]  b;
   logic        eos;
   logic        is_open;
   logic        taken;
   logic        complete;
   logic [20:0] cp_next;
   logic [20:0] least;
   logic        cp_ok;
   logic [2:0]  rep0;
   cmd_type     cmd_c;

   assign req_ready = cmd_ready;
   assign accept    = req_valid && req_ready;
   assign b         = req_in_byte;
   assign eos       = req_end_of_string;
   assign is_open   = (elen_ff != 3'd0);
   assign taken     = is_open && (b[7:6] == 2'b10);
   assign cp_next   = {cp_ff[14:0], b[5:0]};
   assign complete  = taken && (({1'b0, pcnt_ff} + 3'd1) >= elen_ff);

   always_comb begin
      priority if (elen_ff == 3'd2) least = MIN_CP_2;
      else if (elen_ff == 3'd3) least = MIN_CP_3;
      else least = MIN_CP_4;
      cp_ok = (cp_next >= least) && (cp_next <= CP_MAX)
              && !((cp_next >= SURR_LO) && (cp_next <= SURR_HI))
              && (cp_next != NONCHAR_LO) && (cp_next != NONCHAR_HI);
   end

   always_comb begin
      cmd_c         = '0;
      cmd_c.body    = BODY_NONE;
      cmd_c.text    = TEXT_REPL;
      cmd_c.eos     = eos;
      pend_in       = pend_ff;
      pcnt_in       = pcnt_ff;
      elen_in       = elen_ff;
      cp_in         = cp_ff;
      rep0          = is_open ? {1'b0, pcnt_ff} : 3'd0;
      if (taken) begin
         if (complete) begin
            if (cp_ok) begin
               cmd_c.body    = BODY_RAW;
               cmd_c.raw_len = elen_ff;
               cmd_c.raw[0]  = (pcnt_ff == 2'd0) ? b : pend_ff[0];
               cmd_c.raw[1]  = (pcnt_ff == 2'd1) ? b : pend_ff[1];
               cmd_c.raw[2]  = (pcnt_ff == 2'd2) ? b : pend_ff[2];
               cmd_c.raw[3]  = b;
            end else begin
               cmd_c.rep = elen_ff;
            end
            pcnt_in = 2'd0;
            elen_in = 3'd0;
            cp_in   = '0;
         end else begin
            pend_in[pcnt_ff] = b;
            pcnt_in          = pcnt_ff + 2'd1;
            cp_in            = cp_next;
            if (eos) begin
               cmd_c.rep = {1'b0, pcnt_ff} + 3'd1;
               pcnt_in   = 2'd0;
               elen_in   = 3'd0;
               cp_in     = '0;
            end
         end
      end else begin
         // Broken or no sequence: flush held bytes, then decode this byte afresh.
         cmd_c.rep = rep0;
         pcnt_in   = 2'd0;
         elen_in   = 3'd0;
         cp_in     = '0;
         if (b[7] == 1'b0) begin
            priority if (b < CH_SPACE && b != CH_TAB && b != CH_LF && b != CH_CR) begin
               cmd_c.rep = rep0 + 3'd1;
            end else if (b == CH_AMP) begin
               cmd_c.body = BODY_TEXT;
               cmd_c.text = TEXT_AMP;
            end else if (b == CH_LT) begin
               cmd_c.body = BODY_TEXT;
               cmd_c.text = TEXT_LT;
            end else if (b == CH_GT) begin
               cmd_c.body = BODY_TEXT;
               cmd_c.text = TEXT_GT;
            end else if (b == CH_QUOT && req_quote_escape) begin
               cmd_c.body = BODY_TEXT;
               cmd_c.text = TEXT_QUOT;
            end else if (b == CH_APOS && req_quote_escape) begin
               cmd_c.body = BODY_TEXT;
               cmd_c.text = TEXT_APOS;
            end else begin
               cmd_c.body    = BODY_RAW;
               cmd_c.raw_len = 3'd1;
               cmd_c.raw[0]  = b;
            end
         end else if ((b >= LEAD2_LO && b <= LEAD2_HI) || (b >= LEAD3_LO && b <= LEAD3_HI)
                      || (b >= LEAD4_LO && b <= LEAD4_HI)) begin
            priority if (b <= LEAD2_HI) begin
               elen_in = 3'd2;
               cp_in   = {16'h0, b[4:0]};
            end else if (b <= LEAD3_HI) begin
               elen_in = 3'd3;
               cp_in   = {17'h0, b[3:0]};
            end else begin
               elen_in = 3'd4;
               cp_in   = {18'h0, b[2:0]};
            end
            pend_in[0] = b;
            pcnt_in    = 2'd1;
            if (eos) begin
               // lead byte alone at end of string
               cmd_c.rep = rep0 + 3'd1;
               pcnt_in   = 2'd0;
               elen_in   = 3'd0;
               cp_in     = '0;
            end
         end else begin
            cmd_c.rep = rep0 + 3'd1;
         end
      end
   end

   assign cmd       = cmd_c;
   assign cmd_valid = accept && ((cmd_c.rep != 3'd0) || (cmd_c.body != BODY_NONE));

   always_ff @(posedge clock) begin
      if (reset) begin
         pcnt_ff <= 2'd0;
         elen_ff <= 3'd0;
         cp_ff   <= '0;
      end else if (accept) begin
         pcnt_ff <= pcnt_in;
         elen_ff <= elen_in;
         cp_ff   <= cp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         pend_ff <= pend_in;
      end
   end

endmodule

[rtl/core/utfx_queue.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// utfx_queue
// Two-word command queue between the classifier and the expander.
// -----------------------------------------------------------------------------
module utfx_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              wr_valid,
   output logic              wr_ready,
   input  utfx_pkg::cmd_type wr_cmd,
   output logic              rd_valid,
   input  logic              rd_pop,
   output utfx_pkg::cmd_type rd_cmd
);
   import utfx_pkg::*;

   cmd_type    slot_ff [2];
   logic       wptr_ff, wptr_in;
   logic       rptr_ff, rptr_in;
   logic [1:0] count_ff, count_in;
   logic       push;
   logic       pop;

   assign wr_ready = (count_ff != 2'd2);
   assign rd_valid = (count_ff != 2'd0);
   assign rd_cmd   = slot_ff[rptr_ff];
   assign push     = wr_valid && wr_ready;
   assign pop      = rd_pop && rd_valid;

   always_comb begin
      wptr_in  = push ? !wptr_ff : wptr_ff;
      rptr_in  = pop ? !rptr_ff : rptr_ff;
      count_in = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= 1'b0;
         rptr_ff  <= 1'b0;
         count_ff <= 2'd0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wptr_ff] <= wr_cmd;
      end
   end

endmodule

[rtl/core/utfx_back.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// utfx_back
// Output side: expands one command word into escaped text, one byte a cycle
// while the output is not stalled, into the output register.
// -----------------------------------------------------------------------------
module utfx_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  utfx_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [7:0]        rsp_out_byte,
   output logic              rsp_run_last,
   output logic              rsp_string_end
);
   import utfx_pkg::*;

   logic [2:0] rdone_ff, rdone_in;   // replacement texts already sent
   logic [2:0] pos_ff, pos_in;       // byte within current text or raw run
   logic       vld_ff;
   logic [7:0] byte_ff;
   logic       last_ff;
   logic       end_ff;

   logic       advance;
   logic       in_rep;
   logic       piece_last;
   logic       cmd_last;
   logic [7:0] byte_c;

   assign advance = cmd_valid && (!vld_ff || rsp_ready);
   assign in_rep  = (rdone_ff < cmd.rep);

   always_comb begin
      if (in_rep) begin
         byte_c     = text_byte(TEXT_REPL, pos_ff);
         piece_last = (pos_ff == text_last(TEXT_REPL));
         cmd_last   = piece_last && ((rdone_ff + 3'd1) == cmd.rep) && (cmd.body == BODY_NONE);
      end else if (cmd.body == BODY_TEXT) begin
         byte_c     = text_byte(cmd.text, pos_ff);
         piece_last = (pos_ff == text_last(cmd.text));
         cmd_last   = piece_last;
      end else begin
         byte_c     = cmd.raw[pos_ff[1:0]];
         piece_last = (pos_ff == (cmd.raw_len - 3'd1));
         cmd_last   = piece_last;
      end
   end

   always_comb begin
      rdone_in = rdone_ff;
      pos_in   = pos_ff;
      if (advance) begin
         if (cmd_last) begin
            rdone_in = 3'd0;
            pos_in   = 3'd0;
         end else if (in_rep && piece_last) begin
            rdone_in = rdone_ff + 3'd1;
            pos_in   = 3'd0;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   assign cmd_pop = advance && cmd_last;

   always_ff @(posedge clock) begin
      if (reset) begin
         rdone_ff <= 3'd0;
         pos_ff   <= 3'd0;
         vld_ff   <= 1'b0;
      end else begin
         rdone_ff <= rdone_in;
         pos_ff   <= pos_in;
         if (advance) begin
            vld_ff <= 1'b1;
         end else if (rsp_ready) begin
            vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         byte_ff <= byte_c;
         last_ff <= cmd_last;
         end_ff  <= cmd_last && cmd.eos;
      end
   end

   assign rsp_valid      = vld_ff;
   assign rsp_out_byte   = byte_ff;
   assign rsp_run_last   = last_ff;
   assign rsp_string_end = end_ff;

endmodule

[verif/utf8_validating_xml_escaper_test.sv]
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// utf8_validating_xml_escaper_test
// Streams directed and random strings through the escaper under random
// input gaps and output stalls. Each escaped byte is checked against the
// typed row's text or a behavioral model of UTF-8 check and XML escaping.
// -----------------------------------------------------------------------------
module utf8_validating_xml_escaper_test;
   import utfx_pkg::*;

   localparam int NUM_DIR      = 31;
   localparam int RANDOM_ITEMS = 430;
   localparam int MAX_WORDS    = 32;
   localparam int LONG_HOLD    = 400;
   localparam int DRAIN        = 40;
   localparam int CYCLE_LIMIT  = 900000;

   typedef struct packed {
      logic [7:0]  in_byte;
      logic        eos;
      logic        quote;
      logic        typed;     // expected text given in the row itself
      logic [3:0]  n;
      logic [63:0] txt;
   } stim_row_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       run_last;
      logic       string_end;
   } text_word_type;

   logic       clock;
   logic       reset             = 1'b1;
   logic       req_valid         = 1'b0;
   logic       req_ready;
   logic [7:0] req_in_byte       = 8'h00;
   logic       req_end_of_string = 1'b0;
   logic       req_quote_escape  = 1'b0;
   logic       rsp_valid;
   logic       rsp_ready         = 1'b0;
   logic [7:0] rsp_out_byte;
   logic       rsp_run_last;
   logic       rsp_string_end;

   utf8_validating_xml_escaper uut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_end_of_string (req_end_of_string),
      .req_quote_escape  (req_quote_escape),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_run_last      (rsp_run_last),
      .rsp_string_end    (rsp_string_end)
   );

   stim_row_type  dir_tab [0:NUM_DIR-1];
   stim_row_type  stim [$];
   text_word_type text_due [$];
   int            words_in  = 0;
   int            errors    = 0;
   int            cycle_cnt = 0;
   logic          no_idle   = 1'b0;

   // escaper model state
   logic [7:0]  held [0:2];
   logic [1:0]  held_cnt = 2'd0;
   logic [2:0]  seq_len  = 3'd0;
   logic [20:0] cp_acc   = 21'd0;
   logic [7:0]  step_buf [0:MAX_WORDS-1];
   int          step_n;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   end

   always @(posedge clock) cycle_cnt <= cycle_cnt + 1;

   initial begin
      wait (cycle_cnt >= CYCLE_LIMIT);
      $display("utf8_validating_xml_escaper_test NOT OK");
      $finish;
   end

   function automatic stim_row_type stim_row(input logic [7:0] b, input logic eos,
                                             input logic quote, input logic typed,
                                             input logic [3:0] n, input logic [63:0] txt);
      stim_row_type r;
      r.in_byte = b;
      r.eos     = eos;
      r.quote   = quote;
      r.typed   = typed;
      r.n       = n;
      r.txt     = txt;
      return r;
   endfunction

   function automatic logic legal_scalar(input logic [20:0] cp, input logic [2:0] len);
      logic [20:0] least;
      least = (len == 3'd2) ? MIN_CP_2 : (len == 3'd3) ? MIN_CP_3 : MIN_CP_4;
      return !(cp < least || cp > CP_MAX || (cp >= SURR_LO && cp <= SURR_HI) ||
               cp == NONCHAR_LO || cp == NONCHAR_HI);
   endfunction

   task automatic emit_byte(input logic [7:0] b);
      if (step_n < MAX_WORDS) begin
         step_buf[step_n] = b;
         step_n++;
      end
   endtask

   task automatic emit_text(input logic [63:0] txt, input int len);
      int i;
      for (i = 0; i < len; i++)
         emit_byte(txt[63 - 8 * i -: 8]);
   endtask

   task automatic emit_repl(input int times);
      int i;
      for (i = 0; i < times; i++)
         emit_text(TXT_REPL, 8);
   endtask

   task automatic drop_sequence();
      held_cnt = 2'd0;
      seq_len  = 3'd0;
      cp_acc   = 21'd0;
   endtask

   // Escaped bytes caused by one input byte land in step_buf[0:step_n-1].
   task automatic escape_byte(input logic [7:0] b, input logic eos, input logic quote);
      logic taken;
      int   i;
      taken  = 1'b0;
      step_n = 0;
      if (seq_len != 3'd0) begin
         if (b[7:6] == 2'b10) begin
            taken  = 1'b1;
            cp_acc = {cp_acc[14:0], b[5:0]};
            if (int'(held_cnt) + 1 >= int'(seq_len)) begin
               if (legal_scalar(cp_acc, seq_len)) begin
                  for (i = 0; i < int'(held_cnt); i++)
                     emit_byte(held[i]);
                  emit_byte(b);
               end else begin
                  emit_repl(int'(seq_len));
               end
               drop_sequence();
            end else begin
               held[held_cnt] = b;
               held_cnt++;
            end
         end else begin
            // broken sequence: replace what is held, then decode b afresh
            emit_repl(int'(held_cnt));
            drop_sequence();
         end
      end
      if (!taken) begin
         if (!b[7]) begin
            if (b < CH_SPACE && b != CH_TAB && b != CH_LF && b != CH_CR)
               emit_repl(1);
            else if (b == CH_AMP)
               emit_text(TXT_AMP, 5);
            else if (b == CH_LT)
               emit_text(TXT_LT, 4);
            else if (b == CH_GT)
               emit_text(TXT_GT, 4);
            else if (b == CH_QUOT && quote)
               emit_text(TXT_QUOT, 6);
            else if (b == CH_APOS && quote)
               emit_text(TXT_APOS, 6);
            else
               emit_byte(b);
         end else if (b >= LEAD2_LO && b <= LEAD2_HI) begin
            seq_len  = 3'd2;
            cp_acc   = {16'h0, b[4:0]};
            held[0]  = b;
            held_cnt = 2'd1;
         end else if (b >= LEAD3_LO && b <= LEAD3_HI) begin
            seq_len  = 3'd3;
            cp_acc   = {17'h0, b[3:0]};
            held[0]  = b;
            held_cnt = 2'd1;
         end else if (b >= LEAD4_LO && b <= LEAD4_HI) begin
            seq_len  = 3'd4;
            cp_acc   = {18'h0, b[2:0]};
            held[0]  = b;
            held_cnt = 2'd1;
         end else begin
            emit_repl(1);
         end
      end
      if (eos && held_cnt != 2'd0) begin
         emit_repl(int'(held_cnt));
         drop_sequence();
      end
   endtask

   // One string: mostly well-formed characters, some bad forms, cut-off
   // sequences and noise. Quote mode holds for the whole string.
   task automatic add_random_string();
      logic [7:0]  text [$];
      logic [7:0]  enc [0:3];
      logic [7:0]  bt;
      logic [20:0] cp;
      logic        quote;
      int          chars, c, kind, len, keep, i;
      quote = 1'($urandom_range(0, 1));
      chars = $urandom_range(1, 12);
      for (c = 0; c < chars; c++) begin
         kind = $urandom_range(0, 99);
         if (kind < 25) begin
            bt = 8'($urandom_range(8'h20, 8'h7E));
            text.push_back(bt);
         end else if (kind < 35) begin
            case ($urandom_range(0, 4))
               0:       text.push_back(CH_AMP);
               1:       text.push_back(CH_LT);
               2:       text.push_back(CH_GT);
               3:       text.push_back(CH_QUOT);
               default: text.push_back(CH_APOS);
            endcase
         end else if (kind < 43) begin
            bt = 8'($urandom_range(0, 8'h7F));
            text.push_back(bt);
         end else if (kind < 95) begin
            if (kind < 57) begin
               len = 2;
               cp  = 21'($urandom_range(21'h80, 21'h7FF));
            end else if (kind < 70) begin
               len = 3;
               cp  = 21'($urandom_range(21'h800, 21'hFFFF));
            end else if (kind < 80) begin
               len = 4;
               cp  = 21'($urandom_range(21'h10000, 21'h10FFFF));
            end else begin
               case ($urandom_range(0, 5))
                  0: begin   // overlong
                     len = $urandom_range(2, 4);
                     cp  = (len == 2) ? 21'($urandom_range(0, 21'h7F)) :
                           (len == 3) ? 21'($urandom_range(0, 21'h7FF)) :
                                        21'($urandom_range(0, 21'hFFFF));
                  end
                  1: begin
                     len = 3;
                     cp  = 21'($urandom_range(SURR_LO, SURR_HI));
                  end
                  2: begin
                     len = 4;
                     cp  = 21'($urandom_range(21'h110000, 21'h1FFFFF));
                  end
                  3: begin
                     len = 3;
                     cp  = $urandom_range(0, 1) ? NONCHAR_LO : NONCHAR_HI;
                  end
                  4: begin
                     len = 4;
                     cp  = CP_MAX;
                  end
                  default: begin
                     len = 3;
                     cp  = $urandom_range(0, 1) ? 21'h00D7FF : 21'h00E000;
                  end
               endcase
            end
            keep = (kind >= 88) ? $urandom_range(1, len - 1) : len;
            case (len)
               2: begin
                  enc[0] = {3'b110, cp[10:6]};
                  enc[1] = {2'b10, cp[5:0]};
               end
               3: begin
                  enc[0] = {4'b1110, cp[15:12]};
                  enc[1] = {2'b10, cp[11:6]};
                  enc[2] = {2'b10, cp[5:0]};
               end
               default: begin
                  enc[0] = {5'b11110, cp[20:18]};
                  enc[1] = {2'b10, cp[17:12]};
                  enc[2] = {2'b10, cp[11:6]};
                  enc[3] = {2'b10, cp[5:0]};
               end
            endcase
            for (i = 0; i < keep; i++)
               text.push_back(enc[i]);
         end else begin
            bt = 8'($urandom);
            text.push_back(bt);
         end
      end
      for (i = 0; i < text.size(); i++)
         stim.push_back(stim_row(text[i], i == text.size() - 1, quote, 1'b0, 4'd0, 64'h0));
   endtask

   task automatic build_stimulus();
      int i;
      dir_tab[0]  = stim_row(8'h41,   1'b0, 1'b0, 1'b1, 4'd1, {8'h41, 56'h0});
      dir_tab[1]  = stim_row(8'h00,   1'b0, 1'b0, 1'b1, 4'd8, TXT_REPL);
      dir_tab[2]  = stim_row(CH_TAB,  1'b0, 1'b0, 1'b1, 4'd1, {CH_TAB, 56'h0});
      dir_tab[3]  = stim_row(8'h1F,   1'b0, 1'b0, 1'b1, 4'd8, TXT_REPL);
      dir_tab[4]  = stim_row(CH_GT,   1'b0, 1'b0, 1'b1, 4'd4, TXT_GT);
      dir_tab[5]  = stim_row(CH_QUOT, 1'b1, 1'b0, 1'b1, 4'd1, {CH_QUOT, 56'h0});
      dir_tab[6]  = stim_row(8'h7F,   1'b0, 1'b1, 1'b1, 4'd1, {8'h7F, 56'h0});
      dir_tab[7]  = stim_row(CH_AMP,  1'b0, 1'b1, 1'b1, 4'd5, TXT_AMP);
      dir_tab[8]  = stim_row(CH_LT,   1'b0, 1'b1, 1'b1, 4'd4, TXT_LT);
      dir_tab[9]  = stim_row(CH_QUOT, 1'b0, 1'b1, 1'b1, 4'd6, TXT_QUOT);
      dir_tab[10] = stim_row(CH_APOS, 1'b1, 1'b1, 1'b1, 4'd6, TXT_APOS);
      dir_tab[11] = stim_row(8'h80,   1'b0, 1'b0, 1'b1, 4'd8, TXT_REPL);
      dir_tab[12] = stim_row(8'hFF,   1'b0, 1'b0, 1'b1, 4'd8, TXT_REPL);
      dir_tab[13] = stim_row(8'hC3,   1'b0, 1'b0, 1'b1, 4'd0, 64'h0);
      dir_tab[14] = stim_row(8'hA9,   1'b0, 1'b0, 1'b1, 4'd2, {8'hC3, 8'hA9, 48'h0});
      // overlong three-byte form
      dir_tab[15] = stim_row(8'hE0,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[16] = stim_row(8'h80,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[17] = stim_row(8'h80,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      // surrogate
      dir_tab[18] = stim_row(8'hED,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[19] = stim_row(8'hA0,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[20] = stim_row(8'h80,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      // above 10FFFF
      dir_tab[21] = stim_row(8'hF4,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[22] = stim_row(8'h90,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[23] = stim_row(8'h80,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[24] = stim_row(8'h80,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      // lead broken by ASCII
      dir_tab[25] = stim_row(8'hE2,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[26] = stim_row(8'h41,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      // three held bytes broken by a new lead at end of string: 32 words
      dir_tab[27] = stim_row(8'hF0,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[28] = stim_row(8'h9F,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[29] = stim_row(8'h98,   1'b0, 1'b0, 1'b0, 4'd0, 64'h0);
      dir_tab[30] = stim_row(8'hF0,   1'b1, 1'b0, 1'b0, 4'd0, 64'h0);
      for (i = 0; i < NUM_DIR; i++)
         stim.push_back(dir_tab[i]);
      while (stim.size() < NUM_DIR + RANDOM_ITEMS)
         add_random_string();
   endtask

   task automatic note_mismatch(input string field, input logic [7:0] exp_val,
                                input logic [7:0] act_val);
      errors++;
      $error("%s: expected %h, actual %h", field, exp_val, act_val);
   endtask

   // Predict on each accepted input word, check each accepted output word.
   always @(posedge clock) begin : track_words
      stim_row_type  cur;
      text_word_type want;
      logic [63:0]   t;
      logic          last;
      int            i;
      if (!reset) begin
         if (req_valid && req_ready) begin
            escape_byte(req_in_byte, req_end_of_string, req_quote_escape);
            cur = stim[words_in];
            if (cur.typed) begin
               t      = cur.txt;
               step_n = int'(cur.n);
               for (i = 0; i < step_n; i++)
                  step_buf[i] = t[63 - 8 * i -: 8];
            end
            for (i = 0; i < step_n; i++) begin
               last = (i == step_n - 1);
               text_due.push_back({step_buf[i], last, last & req_end_of_string});
            end
            words_in++;
         end
         if (rsp_valid && rsp_ready) begin
            if (text_due.size() == 0) begin
               errors++;
               $error("unexpected output word: out_byte %h", rsp_out_byte);
            end else begin
               want = text_due.pop_front();
               if (rsp_out_byte !== want.out_byte)
                  note_mismatch("out_byte", want.out_byte, rsp_out_byte);
               if (rsp_run_last !== want.run_last)
                  note_mismatch("run_last", {7'b0, want.run_last}, {7'b0, rsp_run_last});
               if (rsp_string_end !== want.string_end)
                  note_mismatch("string_end", {7'b0, want.string_end},
                                {7'b0, rsp_string_end});
            end
         end
      end
   end

   // Output side: random stalls, one long hold-off once traffic is flowing.
   initial begin : receiver
      int   stall;
      logic held_off;
      held_off = 1'b0;
      wait (reset == 1'b0);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 11);
         if (!held_off && words_in >= NUM_DIR + 150) begin
            stall    = LONG_HOLD;
            held_off = 1'b1;
         end
         if (stall != 0) begin
            @(negedge clock);
            rsp_ready <= 1'b0;
            repeat (stall - 1) @(negedge clock);
         end
         @(negedge clock);
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!rsp_valid);
      end
   end

   // Input side and end of run.
   initial begin : sender
      int   gap, k;
      logic pause;
      build_stimulus();
      wait (reset == 1'b0);
      for (k = 0; k < stim.size(); k++) begin
         no_idle = (k >= NUM_DIR + 60 && k < NUM_DIR + 130);
         pause   = (k == NUM_DIR || k == NUM_DIR + 300);
         gap     = no_idle ? 0 : $urandom_range(0, 11);
         if (pause && gap == 0)
            gap = 1;
         if (gap != 0) begin
            @(negedge clock);
            req_valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
            // pause: let the block drain before going on
            do @(negedge clock); while (pause && text_due.size() != 0);
         end else begin
            @(negedge clock);
         end
         req_valid         <= 1'b1;
         req_in_byte       <= stim[k].in_byte;
         req_end_of_string <= stim[k].eos;
         req_quote_escape  <= stim[k].quote;
         do @(posedge clock); while (!req_ready);
      end
      @(negedge clock);
      req_valid <= 1'b0;
      no_idle   = 1'b0;
      while (text_due.size() != 0) @(posedge clock);
      repeat (DRAIN) @(posedge clock);
      if (errors == 0)
         $display("utf8_validating_xml_escaper_test OK");
      else
         $display("utf8_validating_xml_escaper_test NOT OK");
      $finish;
   end

endmodule

[sim.f]
rtl/core/utfx_pkg.sv
rtl/core/utfx_front.sv
rtl/core/utfx_queue.sv
rtl/core/utfx_back.sv
rtl/core/utf8_validating_xml_escaper.sv
verif/utf8_validating_xml_escaper_test.sv
